// File: src/smfr_pkg.sv
// Package for the SPI master register block: register map, sizes and queue pointer helpers.
package smfr_pkg;

    // Receive queue depth and number of implemented chip select lines.
    localparam int RX_DEPTH = 8;
    localparam int CS_LINES = 4;

    // Queue pointers count modulo twice the depth so that full and empty differ.
    localparam int RX_PTR_W = $clog2(2 * RX_DEPTH);
    localparam int RX_IDX_W = $clog2(RX_DEPTH);

    localparam logic [RX_PTR_W-1:0] RX_PTR_LAST  = RX_PTR_W'(2 * RX_DEPTH - 1);
    localparam logic [RX_PTR_W-1:0] RX_DEPTH_PTR = RX_PTR_W'(RX_DEPTH);
    localparam logic [RX_PTR_W:0]   RX_PTR_SPAN  = (RX_PTR_W + 1)'(2 * RX_DEPTH);

    // Access kinds.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Chip select modes.
    localparam logic [1:0] CS_AUTO = 2'd0;
    localparam logic [1:0] CS_HOLD = 2'd2;
    localparam logic [1:0] CS_OFF  = 2'd3;

    // Register byte offsets.
    typedef enum logic [11:0] {
        REG_SCKDIV  = 12'h000,
        REG_SCKMODE = 12'h004,
        REG_CSID    = 12'h010,
        REG_CSDEF   = 12'h014,
        REG_CSMODE  = 12'h018,
        REG_DELAY_A = 12'h028,
        REG_DELAY_B = 12'h02C,
        REG_FMT     = 12'h040,
        REG_TXDATA  = 12'h048,
        REG_RXDATA  = 12'h04C,
        REG_TXMARK  = 12'h050,
        REG_RXMARK  = 12'h054,
        REG_FCTRL   = 12'h060,
        REG_FFMT    = 12'h064,
        REG_IE      = 12'h070,
        REG_IP      = 12'h074
    } reg_offset_t;

    // Frame format bit that suppresses the receive side.
    localparam int FMT_TXONLY_BIT = 3;

    // Answer byte taken when the chip select is off.
    localparam logic [7:0] OFF_ANSWER = 8'hFF;

    // Read value of RXDATA when the queue is empty.
    localparam logic [31:0] RX_EMPTY_FLAG = 32'h8000_0000;

    // Advance a queue pointer with wrap at twice the depth.
    function automatic logic [RX_PTR_W-1:0] rx_ptr_inc(input logic [RX_PTR_W-1:0] p);
        return (p == RX_PTR_LAST) ? '0 : RX_PTR_W'(p + 1'b1);
    endfunction

    // Storage index selected by a queue pointer.
    function automatic logic [RX_IDX_W-1:0] rx_ptr_index(input logic [RX_PTR_W-1:0] p);
        return (p >= RX_DEPTH_PTR) ? RX_IDX_W'(p - RX_DEPTH_PTR) : RX_IDX_W'(p);
    endfunction

    // Number of bytes held in the queue.
    function automatic logic [RX_PTR_W-1:0] rx_fill(input logic [RX_PTR_W-1:0] wr,
                                                    input logic [RX_PTR_W-1:0] rd);
        return (wr >= rd) ? RX_PTR_W'(wr - rd)
                          : RX_PTR_W'({1'b0, wr} + RX_PTR_SPAN - {1'b0, rd});
    endfunction

    // Pending bits: transmit watermark nonzero, queue fill above receive watermark.
    function automatic logic [1:0] pending_bits(input logic [2:0]          tx_mark,
                                                input logic [2:0]          rx_mark,
                                                input logic [RX_PTR_W-1:0] fill);
        return {(RX_PTR_W + 3)'(fill) > (RX_PTR_W + 3)'(rx_mark), tx_mark != 3'd0};
    endfunction

endpackage

// File: src/spi_master_fifo_registers.sv
// Top level of the SPI master register block in FIFO mode.
//
// Each request on the s_ channel is one 32-bit register access: s_func picks
// read or write, s_offset the byte offset, s_write_data the value, and
// s_slave_byte the byte the slave returns during a TXDATA frame. Every
// request yields exactly one result on the m_ channel: read data, chip
// select release and select events, the frame sent to the slave, and the
// interrupt level after the access.
// A request is captured in an input register, decoded and applied to the
// register file and receive queue in one pass, and its result lands in an
// output register, which drives m_valid.
// Throughput is one request per cycle while the receiver takes each result;
// the single decode pass between the two registers sets that figure.
// If the receiver stalls, the result stays in the output register while
// one more request waits in the input register; s_ready then drops until
// m_ready returns. A synchronous low on aresetn empties both registers and
// the receive queue, releases any held select and loads the register reset
// values; queue storage itself is not cleared.
module spi_master_fifo_registers
    import smfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [11:0] s_offset,
    input  logic [31:0] s_write_data,
    input  logic [7:0]  s_slave_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_release_valid,
    output logic [4:0]  m_released_cs,
    output logic        m_select_valid,
    output logic        m_frame_valid,
    output logic [4:0]  m_frame_cs,
    output logic [7:0]  m_mosi_byte,
    output logic        m_frame_pulsed,
    output logic        m_irq_out
);

    // Input register.
    logic        in_valid_reg;
    logic        in_func_reg;
    logic [11:0] in_offset_reg;
    logic [31:0] in_data_reg;
    logic [7:0]  in_slave_reg;

    // Output register.
    logic        out_valid_reg;
    logic [31:0] out_read_data_reg;
    logic        out_release_valid_reg;
    logic [4:0]  out_released_cs_reg;
    logic        out_select_valid_reg;
    logic        out_frame_valid_reg;
    logic [4:0]  out_frame_cs_reg;
    logic [7:0]  out_mosi_byte_reg;
    logic        out_frame_pulsed_reg;
    logic        out_irq_reg;

    // Register file.
    logic [11:0]         sckdiv_reg,  sckdiv_next;
    logic [1:0]          sckmode_reg, sckmode_next;
    logic [4:0]          csid_reg,    csid_next;
    logic [CS_LINES-1:0] csdef_reg,   csdef_next;
    logic [1:0]          csmode_reg,  csmode_next;
    logic [31:0]         delay_a_reg, delay_a_next;
    logic [31:0]         delay_b_reg, delay_b_next;
    logic [31:0]         fmt_reg,     fmt_next;
    logic [2:0]          txmark_reg,  txmark_next;
    logic [2:0]          rxmark_reg,  rxmark_next;
    logic                fctrl_reg,   fctrl_next;
    logic [31:0]         ffmt_reg,    ffmt_next;
    logic [1:0]          ie_reg,      ie_next;

    // Receive queue and select hold state.
    logic [7:0]          rx_store_reg [RX_DEPTH];
    logic [RX_PTR_W-1:0] rx_wr_reg, rx_wr_next;
    logic [RX_PTR_W-1:0] rx_rd_reg, rx_rd_next;
    logic                held_valid_reg, held_valid_next;
    logic [4:0]          held_cs_reg,    held_cs_next;
    logic                irq_reg,        irq_next;

    // Per-request results and queue write controls.
    logic                advance;
    logic [31:0]         read_data;
    logic                release_valid;
    logic [4:0]          released_cs;
    logic                select_valid;
    logic                frame_valid;
    logic [4:0]          frame_cs;
    logic [7:0]          mosi_byte;
    logic                frame_pulsed;
    logic                refresh;
    logic                rx_push;
    logic [7:0]          rx_answer;
    logic [RX_PTR_W-1:0] rx_level;

    // Handshake: the pass runs when the output register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign rx_level = rx_fill(rx_wr_reg, rx_rd_reg);

    // Decode the request and compute the next state and the result.
    always_comb begin
        sckdiv_next     = sckdiv_reg;
        sckmode_next    = sckmode_reg;
        csid_next       = csid_reg;
        csdef_next      = csdef_reg;
        csmode_next     = csmode_reg;
        delay_a_next    = delay_a_reg;
        delay_b_next    = delay_b_reg;
        fmt_next        = fmt_reg;
        txmark_next     = txmark_reg;
        rxmark_next     = rxmark_reg;
        fctrl_next      = fctrl_reg;
        ffmt_next       = ffmt_reg;
        ie_next         = ie_reg;
        rx_wr_next      = rx_wr_reg;
        rx_rd_next      = rx_rd_reg;
        held_valid_next = held_valid_reg;
        held_cs_next    = held_cs_reg;
        read_data       = '0;
        release_valid   = 1'b0;
        released_cs     = '0;
        select_valid    = 1'b0;
        frame_valid     = 1'b0;
        frame_cs        = '0;
        mosi_byte       = '0;
        frame_pulsed    = 1'b0;
        refresh         = 1'b0;
        rx_push         = 1'b0;
        rx_answer       = OFF_ANSWER;

        if (in_func_reg == FUNC_WRITE) begin
            unique case (in_offset_reg)
                REG_SCKDIV:  sckdiv_next  = in_data_reg[11:0];
                REG_SCKMODE: sckmode_next = in_data_reg[1:0];
                REG_CSID: begin
                    if (held_valid_reg && held_cs_reg != in_data_reg[4:0]) begin
                        release_valid   = 1'b1;
                        released_cs     = held_cs_reg;
                        held_valid_next = 1'b0;
                    end
                    csid_next = in_data_reg[4:0];
                end
                REG_CSDEF:   csdef_next   = in_data_reg[CS_LINES-1:0];
                REG_CSMODE: begin
                    if (in_data_reg[1:0] != CS_HOLD && held_valid_reg) begin
                        release_valid   = 1'b1;
                        released_cs     = held_cs_reg;
                        held_valid_next = 1'b0;
                    end
                    csmode_next = in_data_reg[1:0];
                end
                REG_DELAY_A: delay_a_next = in_data_reg;
                REG_DELAY_B: delay_b_next = in_data_reg;
                REG_FMT:     fmt_next     = in_data_reg;
                REG_TXDATA: begin
                    // One byte frame; the select action depends on the mode.
                    if (csmode_reg == CS_OFF) begin
                        if (held_valid_reg) begin
                            release_valid   = 1'b1;
                            released_cs     = held_cs_reg;
                            held_valid_next = 1'b0;
                        end
                        rx_answer = OFF_ANSWER;
                    end else begin
                        if (csmode_reg == CS_HOLD) begin
                            if (!held_valid_reg || held_cs_reg != csid_reg) begin
                                if (held_valid_reg) begin
                                    release_valid = 1'b1;
                                    released_cs   = held_cs_reg;
                                end
                                held_valid_next = 1'b1;
                                held_cs_next    = csid_reg;
                                select_valid    = 1'b1;
                            end
                        end else begin
                            if (held_valid_reg) begin
                                release_valid   = 1'b1;
                                released_cs     = held_cs_reg;
                                held_valid_next = 1'b0;
                            end
                            frame_pulsed = 1'b1;
                        end
                        frame_valid = 1'b1;
                        frame_cs    = csid_reg;
                        mosi_byte   = in_data_reg[7:0];
                        rx_answer   = in_slave_reg;
                    end
                    // Queue the answer unless transmit only or the queue is full.
                    if (!fmt_reg[FMT_TXONLY_BIT] && rx_level < RX_DEPTH_PTR) begin
                        rx_push    = 1'b1;
                        rx_wr_next = rx_ptr_inc(rx_wr_reg);
                    end
                    refresh = 1'b1;
                end
                REG_TXMARK: begin
                    txmark_next = in_data_reg[2:0];
                    refresh     = 1'b1;
                end
                REG_RXMARK: begin
                    rxmark_next = in_data_reg[2:0];
                    refresh     = 1'b1;
                end
                REG_FCTRL:   fctrl_next = in_data_reg[0];
                REG_FFMT:    ffmt_next  = in_data_reg;
                REG_IE: begin
                    ie_next = in_data_reg[1:0];
                    refresh = 1'b1;
                end
                default: ;
            endcase
        end else begin
            unique case (in_offset_reg)
                REG_SCKDIV:  read_data = 32'(sckdiv_reg);
                REG_SCKMODE: read_data = 32'(sckmode_reg);
                REG_CSID:    read_data = 32'(csid_reg);
                REG_CSDEF:   read_data = 32'(csdef_reg);
                REG_CSMODE:  read_data = 32'(csmode_reg);
                REG_DELAY_A: read_data = delay_a_reg;
                REG_DELAY_B: read_data = delay_b_reg;
                REG_FMT:     read_data = fmt_reg;
                REG_RXDATA: begin
                    // Pop one byte, or flag an empty queue.
                    if (rx_level == '0) begin
                        read_data = RX_EMPTY_FLAG;
                    end else begin
                        read_data  = 32'(rx_store_reg[rx_ptr_index(rx_rd_reg)]);
                        rx_rd_next = rx_ptr_inc(rx_rd_reg);
                    end
                    refresh = 1'b1;
                end
                REG_TXMARK:  read_data = 32'(txmark_reg);
                REG_RXMARK:  read_data = 32'(rxmark_reg);
                REG_FCTRL:   read_data = 32'(fctrl_reg);
                REG_FFMT:    read_data = ffmt_reg;
                REG_IE:      read_data = 32'(ie_reg);
                REG_IP:      read_data = 32'(pending_bits(txmark_reg, rxmark_reg, rx_level));
                default: ;
            endcase
        end
    end

    // Interrupt level is recomputed from the post-access state when the access calls for it.
    always_comb begin
        if (refresh) begin
            irq_next = (pending_bits(txmark_next, rxmark_next, rx_fill(rx_wr_next, rx_rd_next))
                        & ie_next) != 2'b00;
        end else begin
            irq_next = irq_reg;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_func_reg   <= s_func;
            in_offset_reg <= s_offset;
            in_data_reg   <= s_write_data;
            in_slave_reg  <= s_slave_byte;
        end
    end

    // Register file, queue pointers, hold state and interrupt level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sckdiv_reg     <= '0;
            sckmode_reg    <= '0;
            csid_reg       <= '0;
            csdef_reg      <= '1;
            csmode_reg     <= CS_AUTO;
            delay_a_reg    <= '0;
            delay_b_reg    <= '0;
            fmt_reg        <= '0;
            txmark_reg     <= 3'd1;
            rxmark_reg     <= '0;
            fctrl_reg      <= 1'b0;
            ffmt_reg       <= '0;
            ie_reg         <= '0;
            rx_wr_reg      <= '0;
            rx_rd_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_cs_reg    <= '0;
            irq_reg        <= 1'b0;
        end else if (advance) begin
            sckdiv_reg     <= sckdiv_next;
            sckmode_reg    <= sckmode_next;
            csid_reg       <= csid_next;
            csdef_reg      <= csdef_next;
            csmode_reg     <= csmode_next;
            delay_a_reg    <= delay_a_next;
            delay_b_reg    <= delay_b_next;
            fmt_reg        <= fmt_next;
            txmark_reg     <= txmark_next;
            rxmark_reg     <= rxmark_next;
            fctrl_reg      <= fctrl_next;
            ffmt_reg       <= ffmt_next;
            ie_reg         <= ie_next;
            rx_wr_reg      <= rx_wr_next;
            rx_rd_reg      <= rx_rd_next;
            held_valid_reg <= held_valid_next;
            held_cs_reg    <= held_cs_next;
            irq_reg        <= irq_next;
        end
    end

    // Receive queue storage.
    always_ff @(posedge aclk) begin
        if (advance && rx_push) begin
            rx_store_reg[rx_ptr_index(rx_wr_reg)] <= rx_answer;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_read_data_reg     <= read_data;
            out_release_valid_reg <= release_valid;
            out_released_cs_reg   <= released_cs;
            out_select_valid_reg  <= select_valid;
            out_frame_valid_reg   <= frame_valid;
            out_frame_cs_reg      <= frame_cs;
            out_mosi_byte_reg     <= mosi_byte;
            out_frame_pulsed_reg  <= frame_pulsed;
            out_irq_reg           <= irq_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_read_data     = out_read_data_reg;
    assign m_release_valid = out_release_valid_reg;
    assign m_released_cs   = out_released_cs_reg;
    assign m_select_valid  = out_select_valid_reg;
    assign m_frame_valid   = out_frame_valid_reg;
    assign m_frame_cs      = out_frame_cs_reg;
    assign m_mosi_byte     = out_mosi_byte_reg;
    assign m_frame_pulsed  = out_frame_pulsed_reg;
    assign m_irq_out       = out_irq_reg;

endmodule
